// File: src/fbpa_pkg.sv
// shared types and constants of the fixed block pool allocator
package fbpa_pkg;

    localparam int DEF_MAX_BLOCKS = 256;
    localparam int ADDR_W         = 32;
    localparam int SIZE_W         = 16;
    localparam int COUNT_W        = 9;
    localparam int STRIDE_W       = 17;
    localparam int FUNC_W         = 2;
    localparam int IN_TDATA_W     = 40;
    localparam int OUT_TDATA_W    = 40;
    localparam int CFG_IDX_W      = 2;

    localparam logic [ADDR_W-1:0]   FIRST_DATA = 32'd16;
    localparam logic [STRIDE_W-1:0] LINK_BYTES = 17'd4;
    localparam logic [STRIDE_W-1:0] ROUND_MASK = 17'd3;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT  = 2'd2;

    localparam logic [ADDR_W-1:0]  RST_BASE_ADDRESS = 32'd0;
    localparam logic [SIZE_W-1:0]  RST_BLOCK_SIZE   = 16'd4;
    localparam logic [COUNT_W-1:0] RST_BLOCK_COUNT  = 9'd1;

    localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FREE    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REBUILD = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NOP     = 2'd3;

    typedef enum logic [1:0] {
        KIND_ALLOC,
        KIND_FREE,
        KIND_REBUILD,
        KIND_NONE
    } fbpa_kind_t;

    typedef struct packed {
        fbpa_kind_t        kind;
        logic [ADDR_W-1:0] offset;
    } fbpa_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALLOC_FIN,
        ST_DIV,
        ST_BUILD,
        ST_RESULT
    } fbpa_state_t;

endpackage

// File: src/fixed_block_pool_allocator.sv
// top level of the fixed block pool allocator: config registers, front end and back end
//
// Hands out and takes back equal-sized blocks of a pool through a LIFO free list
// of block indices kept in an on-chip link memory of MAX_BLOCKS entries. Requests
// (func 0 alloc, 1 free, 2 rebuild, 3 no-op) enter a two-entry queue and each
// gives exactly one result. An alloc does a link memory read and the
// index-times-stride multiply, a free runs the stride check through a
// one-bit-per-cycle 32-step divider, a rebuild writes the links (one link
// written per cycle); requests are worked one at a time.
// The link memory is undefined after reset and gets written by rebuild or free;
// issue a rebuild before the first alloc. Write the config registers only while
// no request is in flight.
module fixed_block_pool_allocator #(
    parameter int MAX_BLOCKS = fbpa_pkg::DEF_MAX_BLOCKS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [fbpa_pkg::IN_TDATA_W-1:0]  s_tdata,   // func[1:0], address_in[33:2]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [fbpa_pkg::OUT_TDATA_W-1:0] m_tdata,   // address_out[31:0], ok[32]
    input  logic                             cfg_we,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fbpa_pkg::ADDR_W-1:0]      cfg_data
);
    import fbpa_pkg::*;

    localparam int IDX_W = $clog2(MAX_BLOCKS + 1);

    logic [ADDR_W-1:0]   base_address_reg;
    logic [SIZE_W-1:0]   block_size_reg;
    logic [COUNT_W-1:0]  block_count_reg;
    logic [STRIDE_W-1:0] stride;
    logic [STRIDE_W-1:0] rounded;
    logic [IDX_W-1:0]    count_eff;
    logic                q_valid;
    logic                q_pop;
    fbpa_req_t           q_req;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_address_reg <= RST_BASE_ADDRESS;
            block_size_reg   <= RST_BLOCK_SIZE;
            block_count_reg  <= RST_BLOCK_COUNT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BASE_ADDRESS: base_address_reg <= cfg_data;
                REG_BLOCK_SIZE:   block_size_reg   <= cfg_data[SIZE_W-1:0];
                REG_BLOCK_COUNT:  block_count_reg  <= cfg_data[COUNT_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        rounded = ({1'b0, block_size_reg} + ROUND_MASK) & ~ROUND_MASK;
        stride  = rounded + LINK_BYTES;
        if (32'(block_count_reg) > 32'(MAX_BLOCKS))
        begin
            count_eff = IDX_W'(MAX_BLOCKS);
        end
        else
        begin
            count_eff = IDX_W'(block_count_reg);
        end
    end

    fbpa_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .base_address (base_address_reg),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_req        (q_req)
    );

    fbpa_back #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .IDX_W      (IDX_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_req        (q_req),
        .base_address (base_address_reg),
        .stride       (stride),
        .count        (count_eff),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

endmodule

// File: src/fbpa_front.sv
// front end: takes requests, classifies them and queues them for the back end
module fbpa_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [fbpa_pkg::IN_TDATA_W-1:0] s_tdata,   // func, address_in
    input  logic [fbpa_pkg::ADDR_W-1:0] base_address,
    output logic                       q_valid,
    input  logic                       q_pop,
    output fbpa_pkg::fbpa_req_t        q_req
);
    import fbpa_pkg::*;

    fbpa_req_t         slot_reg [2];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        cnt_reg, cnt_next;
    logic              push;
    fbpa_req_t         req_in;
    logic [FUNC_W-1:0] func;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] low;

    assign func = s_tdata[FUNC_W-1:0];
    assign addr = s_tdata[FUNC_W+ADDR_W-1:FUNC_W];
    assign low  = base_address + FIRST_DATA;

    always_comb
    begin
        req_in.offset = addr - low;
        unique case (func)
            FUNC_ALLOC:   req_in.kind = KIND_ALLOC;
            FUNC_FREE:    req_in.kind = (addr >= low) ? KIND_FREE : KIND_NONE;
            FUNC_REBUILD: req_in.kind = KIND_REBUILD;
            FUNC_NOP:     req_in.kind = KIND_NONE;
            default:      req_in.kind = KIND_NONE;
        endcase
    end

    assign s_tready = (cnt_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_req    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ q_pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= req_in;
        end
    end

endmodule

// File: src/fbpa_div.sv
// bit-serial restoring divider for the free address stride check
module fbpa_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [fbpa_pkg::ADDR_W-1:0]   dividend,
    input  logic [fbpa_pkg::STRIDE_W-1:0] divisor,
    output logic                          done,
    output logic [fbpa_pkg::ADDR_W-1:0]   quotient,
    output logic [fbpa_pkg::STRIDE_W-1:0] remainder
);
    import fbpa_pkg::*;

    localparam int STEP_W = $clog2(ADDR_W);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [STRIDE_W:0]   rem_reg, rem_next;
    logic [ADDR_W-1:0]   quo_reg, quo_next;
    logic [STRIDE_W-1:0] dsr_reg, dsr_next;
    logic [STRIDE_W:0]   trial;

    assign trial = {rem_reg[STRIDE_W-1:0], quo_reg[ADDR_W-1]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = trial - {1'b0, dsr_reg};
                quo_next = {quo_reg[ADDR_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[ADDR_W-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(ADDR_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg[STRIDE_W-1:0];

endmodule

// File: src/fbpa_back.sv
// back end: free list state, link memory, operation sequencer and result register
module fbpa_back #(
    parameter int MAX_BLOCKS = fbpa_pkg::DEF_MAX_BLOCKS,
    parameter int IDX_W      = $clog2(MAX_BLOCKS + 1)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_valid,
    output logic                            q_pop,
    input  fbpa_pkg::fbpa_req_t             q_req,
    input  logic [fbpa_pkg::ADDR_W-1:0]     base_address,
    input  logic [fbpa_pkg::STRIDE_W-1:0]   stride,
    input  logic [IDX_W-1:0]                count,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [fbpa_pkg::OUT_TDATA_W-1:0] m_tdata  // address_out, ok
);
    import fbpa_pkg::*;

    localparam int AW   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int PR_W = IDX_W + STRIDE_W;
    localparam logic [IDX_W-1:0] END_MARK = IDX_W'(MAX_BLOCKS);

    fbpa_state_t       state_reg, state_next;
    logic [IDX_W-1:0]  head_reg, head_next;
    logic [IDX_W-1:0]  cnt_reg, cnt_next;
    logic [PR_W-1:0]   prod_reg, prod_next;
    logic [ADDR_W-1:0] res_addr_reg, res_addr_next;
    logic              res_ok_reg, res_ok_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [ADDR_W-1:0] out_addr_reg, out_addr_next;
    logic              out_ok_reg, out_ok_next;
    logic              out_free;

    logic [IDX_W-1:0]  link_mem [MAX_BLOCKS];
    logic [IDX_W-1:0]  rd_data_reg;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [IDX_W-1:0]  wr_data;

    logic              div_start;
    logic              div_done;
    logic [ADDR_W-1:0] div_quo;
    logic [STRIDE_W-1:0] div_rem;
    logic [IDX_W-1:0]  cnt_inc;

    fbpa_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (q_req.offset),
        .divisor   (stride),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign out_free = !m_tvalid_reg || m_tready;
    assign cnt_inc  = cnt_reg + 1'b1;

    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        cnt_next      = cnt_reg;
        prod_next     = prod_reg;
        res_addr_next = res_addr_reg;
        res_ok_next   = res_ok_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        out_addr_next = out_addr_reg;
        out_ok_next   = out_ok_reg;
        q_pop         = 1'b0;
        div_start     = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = cnt_reg[AW-1:0];
        wr_data       = head_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop         = 1'b1;
                    res_addr_next = '0;
                    res_ok_next   = 1'b0;
                    state_next    = ST_RESULT;
                    unique case (q_req.kind)
                        KIND_ALLOC:
                        begin
                            if (head_reg != END_MARK)
                            begin
                                prod_next  = PR_W'(head_reg) * PR_W'(stride);
                                state_next = ST_ALLOC_FIN;
                            end
                        end
                        KIND_FREE:
                        begin
                            div_start  = 1'b1;
                            state_next = ST_DIV;
                        end
                        KIND_REBUILD:
                        begin
                            res_ok_next = 1'b1;
                            cnt_next    = '0;
                            if (count == '0)
                            begin
                                head_next = END_MARK;
                            end
                            else
                            begin
                                head_next  = '0;
                                state_next = ST_BUILD;
                            end
                        end
                        KIND_NONE:
                        begin
                            res_ok_next = 1'b0;
                        end
                        default:
                        begin
                            res_ok_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_ALLOC_FIN:
            begin
                head_next     = rd_data_reg;
                res_addr_next = base_address + FIRST_DATA + ADDR_W'(prod_reg);
                res_ok_next   = 1'b1;
                state_next    = ST_RESULT;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    if ((div_rem == '0) && (div_quo < ADDR_W'(count)))
                    begin
                        wr_en       = 1'b1;
                        wr_addr     = div_quo[AW-1:0];
                        wr_data     = head_reg;
                        head_next   = div_quo[IDX_W-1:0];
                        res_ok_next = 1'b1;
                    end
                    state_next = ST_RESULT;
                end
            end
            ST_BUILD:
            begin
                wr_en    = 1'b1;
                wr_addr  = cnt_reg[AW-1:0];
                wr_data  = (cnt_inc < count) ? cnt_inc : END_MARK;
                cnt_next = cnt_inc;
                if (cnt_inc == count)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    out_addr_next = res_addr_reg;
                    out_ok_next   = res_ok_reg;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            head_reg     <= END_MARK;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg      <= cnt_next;
        prod_reg     <= prod_next;
        res_addr_reg <= res_addr_next;
        res_ok_reg   <= res_ok_next;
        out_addr_reg <= out_addr_next;
        out_ok_reg   <= out_ok_next;
    end

    // link memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            link_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= link_mem[head_reg[AW-1:0]];
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - ADDR_W - 1){1'b0}}, out_ok_reg, out_addr_reg};

endmodule

// File: dv/fixed_block_pool_allocator_test.sv
// testbench for the fixed block pool allocator: directed and random requests checked by a pool predictor
`timescale 1ns / 100ps

module fixed_block_pool_allocator_test;
    import fbpa_pkg::*;

    localparam int POOL_LIMIT = 256;
    localparam logic [COUNT_W-1:0] LIST_END = 9'd256;
    localparam int RANDOM_ITEMS = 1150;
    localparam int QUIET_ITEMS = 150;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 60;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic              ok;
    } pool_reply_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [ADDR_W-1:0]      cfg_data = '0;

    // predictor copy of the registers and the free list
    logic [ADDR_W-1:0]  pool_base = RST_BASE_ADDRESS;
    logic [SIZE_W-1:0]  pool_block_size = RST_BLOCK_SIZE;
    logic [COUNT_W-1:0] pool_block_count = RST_BLOCK_COUNT;
    logic [COUNT_W-1:0] free_head = LIST_END;
    logic [COUNT_W-1:0] next_free [POOL_LIMIT];

    pool_reply_t       pending_replies[$];
    logic [ADDR_W-1:0] allocated_addrs[$];
    pool_reply_t       want;
    int                error_count = 0;
    int                items_sent = 0;
    int                quiet_cycles = 0;
    bit                idle_on = 1'b1;

    fixed_block_pool_allocator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [ADDR_W-1:0] block_stride();
        logic [ADDR_W-1:0] rounded;
        rounded = ({16'd0, pool_block_size} + 32'd3) & ~32'd3;
        return rounded + 32'd4;
    endfunction

    function automatic int usable_blocks();
        return pool_block_count > POOL_LIMIT ? POOL_LIMIT : int'(pool_block_count);
    endfunction

    function automatic logic [ADDR_W-1:0] data_address(input int idx);
        return pool_base + 32'd16 + 32'(idx) * block_stride();
    endfunction

    function automatic pool_reply_t predict_pool_op(input logic [FUNC_W-1:0] op,
                                                    input logic [ADDR_W-1:0] addr);
        pool_reply_t       reply;
        logic [ADDR_W-1:0] low;
        logic [ADDR_W-1:0] offset;
        logic [ADDR_W-1:0] idx;
        int                count;
        reply = '0;
        count = usable_blocks();
        case (op)
            FUNC_ALLOC:
            begin
                if (free_head < LIST_END)
                begin
                    reply.address = data_address(int'(free_head));
                    reply.ok = 1'b1;
                    allocated_addrs.push_back(reply.address);
                    free_head = next_free[free_head[7:0]];
                end
            end
            FUNC_FREE:
            begin
                low = pool_base + 32'd16;
                offset = addr - low;
                idx = offset / block_stride();
                if (addr >= low && offset % block_stride() == 0 && idx < count)
                begin
                    next_free[idx[7:0]] = free_head;
                    free_head = idx[COUNT_W-1:0];
                    reply.ok = 1'b1;
                end
            end
            FUNC_REBUILD:
            begin
                for (int i = 0; i < count; i++)
                    next_free[i] = (i + 1 < count) ? 9'(i + 1) : LIST_END;
                free_head = count > 0 ? 9'd0 : LIST_END;
                allocated_addrs.delete();
                reply.ok = 1'b1;
            end
            default:
                reply = '0;
        endcase
        return reply;
    endfunction

    task automatic send_request(input logic [FUNC_W-1:0] op, input logic [ADDR_W-1:0] addr);
        if (idle_on && $urandom_range(3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(12, 1)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(IN_TDATA_W - ADDR_W - FUNC_W){1'b0}}, addr, op};
        do @(posedge clk); while (!s_tready);
        pending_replies.push_back(predict_pool_op(op, addr));
        items_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_BASE_ADDRESS: pool_base = value;
            REG_BLOCK_SIZE:   pool_block_size = value[SIZE_W-1:0];
            REG_BLOCK_COUNT:  pool_block_count = value[COUNT_W-1:0];
            default:          pool_base = pool_base;
        endcase
    endtask

    task automatic test_alloc_free_order();
        write_register(REG_BASE_ADDRESS, 32'h0000_1000);
        write_register(REG_BLOCK_SIZE, 32'd5);
        write_register(REG_BLOCK_COUNT, 32'd2);
        send_request(FUNC_REBUILD, $urandom());
        send_request(FUNC_ALLOC, $urandom());
        send_request(FUNC_ALLOC, $urandom());
        // pool drained
        send_request(FUNC_ALLOC, $urandom());
        send_request(FUNC_FREE, data_address(1));
        send_request(FUNC_FREE, data_address(0));
        send_request(FUNC_ALLOC, $urandom());
        send_request(FUNC_ALLOC, $urandom());
    endtask

    task automatic test_free_rejects();
        send_request(FUNC_FREE, pool_base + 32'd15);
        send_request(FUNC_FREE, data_address(0) + 32'd1);
        send_request(FUNC_FREE, data_address(usable_blocks()));
        send_request(FUNC_FREE, 32'h0000_0000);
        send_request(FUNC_FREE, 32'hFFFF_FFFF);
        send_request(FUNC_NOP, 32'hFFFF_FFFF);
    endtask

    task automatic test_pool_geometry();
        wait_drained();
        write_register(REG_BASE_ADDRESS, 32'h0000_0000);
        write_register(REG_BLOCK_SIZE, 32'h0000_FFFF);
        write_register(REG_BLOCK_COUNT, 32'd2);
        send_request(FUNC_REBUILD, 32'h0);
        send_request(FUNC_ALLOC, 32'h0);
        send_request(FUNC_ALLOC, 32'h0);
        send_request(FUNC_FREE, data_address(1));
        // empty pool after rebuild
        wait_drained();
        write_register(REG_BLOCK_COUNT, 32'd0);
        send_request(FUNC_REBUILD, 32'h0);
        send_request(FUNC_ALLOC, 32'h0);
        // zero block size, count clamped to the pool limit
        wait_drained();
        write_register(REG_BLOCK_SIZE, 32'd0);
        write_register(REG_BLOCK_COUNT, 32'd511);
        send_request(FUNC_REBUILD, 32'h0);
        send_request(FUNC_FREE, data_address(POOL_LIMIT - 1));
        send_request(FUNC_FREE, data_address(POOL_LIMIT));
        // pool crossing the top of the address space
        wait_drained();
        write_register(REG_BASE_ADDRESS, 32'hFFFF_FFE8);
        write_register(REG_BLOCK_SIZE, 32'd4);
        write_register(REG_BLOCK_COUNT, 32'd4);
        send_request(FUNC_REBUILD, 32'h0);
        send_request(FUNC_ALLOC, 32'h0);
        send_request(FUNC_ALLOC, 32'h0);
        send_request(FUNC_FREE, 32'h0000_0000);
        send_request(FUNC_FREE, 32'hFFFF_FFF8);
    endtask

    task automatic test_random_traffic();
        int                target;
        int                op_pick;
        int                addr_pick;
        int                slot;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] value;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target)
        begin
            idle_on = (target - items_sent) > QUIET_ITEMS;
            wait_drained();
            if ($urandom_range(1) == 1)
            begin
                case ($urandom_range(7))
                    0:       value = 32'h0000_0000;
                    1:       value = 32'hFFFF_FFFF;
                    2:       value = 32'hFFFF_F000 | $urandom_range(4095);
                    default: value = $urandom();
                endcase
                write_register(REG_BASE_ADDRESS, value);
            end
            if ($urandom_range(1) == 1)
            begin
                case ($urandom_range(9))
                    0:       value = 32'd0;
                    1:       value = 32'd65532;
                    2:       value = 32'd65533;
                    3:       value = 32'd65535;
                    default: value = $urandom_range(64, 1);
                endcase
                write_register(REG_BLOCK_SIZE, value);
            end
            case ($urandom_range(9))
                0:       value = 32'd0;
                1:       value = 32'd256;
                2:       value = 32'd511;
                3:       value = $urandom_range(511);
                default: value = $urandom_range(16, 1);
            endcase
            write_register(REG_BLOCK_COUNT, value);
            if ($urandom_range(3) != 0)
                send_request(FUNC_REBUILD, $urandom());
            repeat ($urandom_range(60, 20))
            begin
                op_pick = $urandom_range(99);
                if (op_pick < 40)
                    send_request(FUNC_ALLOC, $urandom());
                else if (op_pick < 85)
                begin
                    addr_pick = $urandom_range(99);
                    if (addr_pick < 55 && allocated_addrs.size() != 0)
                    begin
                        slot = $urandom_range(allocated_addrs.size() - 1);
                        addr = allocated_addrs[slot];
                        allocated_addrs.delete(slot);
                    end
                    else if (addr_pick < 70)
                        addr = data_address($urandom_range(usable_blocks() + 1));
                    else if (addr_pick < 80)
                        addr = data_address($urandom_range(usable_blocks()))
                               + $urandom_range(block_stride() - 1, 1);
                    else if (addr_pick < 88)
                        addr = pool_base + $urandom_range(15);
                    else
                        addr = $urandom();
                    send_request(FUNC_FREE, addr);
                end
                else if (op_pick < 92)
                    send_request(FUNC_REBUILD, $urandom());
                else
                    send_request(FUNC_NOP, $urandom());
            end
        end
        wait_drained();
    endtask

    // result side back-pressure
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (idle_on && $urandom_range(5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(12, 1)) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_replies.size() == 0)
            begin
                $error("unexpected result: address_out %h, ok %b", m_tdata[31:0], m_tdata[32]);
                error_count++;
            end
            else
            begin
                want = pending_replies.pop_front();
                if (m_tdata[31:0] !== want.address)
                begin
                    $error("address_out: expected %h, got %h", want.address, m_tdata[31:0]);
                    error_count++;
                end
                if (m_tdata[32] !== want.ok)
                begin
                    $error("ok: expected %b, got %b", want.ok, m_tdata[32]);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("fixed_block_pool_allocator_test NOT OK");
            $finish;
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_alloc_free_order();
        test_free_rejects();
        test_pool_geometry();
        test_random_traffic();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("fixed_block_pool_allocator_test OK");
        else
            $display("fixed_block_pool_allocator_test NOT OK");
        $finish;
    end

endmodule
